// ===== hw/rtl/rgba_alpha_blend_modes_macros.svh =====
// Assertion macros for the alpha blend block.
`ifndef RGBA_ALPHA_BLEND_MODES_MACROS_SVH
`define RGBA_ALPHA_BLEND_MODES_MACROS_SVH
`ifndef SYNTHESIS
`define RAB_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rab assertion failed");
`define RAB_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("rab reset assertion failed");
`else
`define RAB_ASSERT(label, prop)
`define RAB_ASSERT_RST(label, prop)
`endif
`endif

// ===== hw/rtl/rab_pkg.sv =====
// Shared constants, types and helper functions for the alpha blend block.
package rab_pkg;
  localparam int CW = 12;
  localparam int AW = 2 * CW;
  localparam int NW = 3 * CW + 1;
  localparam int QW = CW + 1;
  localparam logic [CW-1:0] FULL = {CW{1'b1}};
  localparam logic [CW-1:0] HALF = FULL >> 1;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ADD    = 2'd1,
    MODE_MUL    = 2'd2,
    MODE_SCREEN = 2'd3
  } mode_e;

  typedef enum logic {
    REG_MODE    = 1'b0,
    REG_OPACITY = 1'b1
  } reg_e;

  typedef struct packed {
    logic          zero;
    logic [AW-1:0] a2;
    logic [2:0][NW-1:0] num;
  } front_t;

  // floor(v / FULL), v below 2^(2*CW+1)
  function automatic logic [CW:0] div_full(input logic [AW:0] v);
    logic [AW+1:0] t;
    logic [AW+1:0] qe;
    logic [AW+1:0] r;
    begin
      t  = {1'b0, v} + ({1'b0, v} >> CW);
      qe = t >> CW;
      r  = {1'b0, v} - ((qe << CW) - qe);
      if (r >= (AW+2)'(FULL)) begin
        qe = qe + 1'b1;
        r  = r - (AW+2)'(FULL);
      end
      if (r >= (AW+2)'(FULL)) begin
        qe = qe + 1'b1;
      end
      div_full = qe[CW:0];
    end
  endfunction

  function automatic logic [CW-1:0] clamp_full(input logic [CW:0] v);
    clamp_full = (v > {1'b0, FULL}) ? FULL : v[CW-1:0];
  endfunction
endpackage

// ===== hw/rtl/rab_front.sv =====
// Front pipeline: opacity, blend modes, alpha and numerator products.
module rab_front import rab_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  logic [1:0]         mode_i,
  input  logic [CW-1:0]      opac_i,
  input  logic [2:0][CW-1:0] dst_i,
  input  logic [CW-1:0]      dst_a_i,
  input  logic [2:0][CW-1:0] src_i,
  input  logic [CW-1:0]      src_a_i,
  output logic               vld_o,
  output front_t             data_o
);
  logic [3:0] vld_q;

  // stage 1
  logic [1:0]         mode1_q;
  logic [2:0][CW-1:0] d1_q, s1_q;
  logic [CW-1:0]      da1_q;
  logic [AW-1:0]      psa1_q;
  logic [2:0][AW-1:0] mul1_q, scr1_q;
  // stage 2
  logic [CW-1:0]      sa2_q, da2_q;
  logic [2:0][CW-1:0] b2_q, d2_q;
  // stage 3
  logic [CW-1:0]      sa3_q;
  logic [AW-1:0]      wd3_q;
  logic [2:0][AW-1:0] bsa3_q;
  logic [2:0][CW-1:0] d3_q;
  // stage 4
  front_t             f4_d, f4_q;

  logic [2:0][CW-1:0] b2_d;
  logic [CW-1:0]      sa2_d;

  always_comb begin
    sa2_d = clamp_full(div_full({1'b0, psa1_q} + (AW+1)'(HALF)));
    for (int c = 0; c < 3; c++) begin
      case (mode_e'(mode1_q))
        MODE_ADD: b2_d[c] = clamp_full({1'b0, d1_q[c]} + {1'b0, s1_q[c]});
        MODE_MUL: b2_d[c] = clamp_full(div_full({1'b0, mul1_q[c]} + (AW+1)'(HALF)));
        MODE_SCREEN: b2_d[c] = FULL -
            clamp_full(div_full({1'b0, scr1_q[c]} + (AW+1)'(HALF)));
        default: b2_d[c] = s1_q[c];
      endcase
    end
  end

  always_comb begin
    logic [NW-1:0] bsaf;
    logic [NW-1:0] dwd;
    f4_d.a2   = ((AW)'(sa3_q) << CW) - (AW)'(sa3_q) + wd3_q;
    f4_d.zero = (f4_d.a2 == '0);
    for (int c = 0; c < 3; c++) begin
      bsaf = ((NW)'(bsa3_q[c]) << CW) - (NW)'(bsa3_q[c]);
      dwd  = (NW)'(d3_q[c]) * (NW)'(wd3_q);
      f4_d.num[c] = bsaf + dwd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode1_q <= mode_i;
      d1_q    <= dst_i;
      s1_q    <= src_i;
      da1_q   <= dst_a_i;
      psa1_q  <= src_a_i * opac_i;
      for (int c = 0; c < 3; c++) begin
        mul1_q[c] <= dst_i[c] * src_i[c];
        scr1_q[c] <= (FULL - dst_i[c]) * (FULL - src_i[c]);
      end
      sa2_q <= sa2_d;
      da2_q <= da1_q;
      b2_q  <= b2_d;
      d2_q  <= d1_q;
      sa3_q <= sa2_q;
      wd3_q <= da2_q * (FULL - sa2_q);
      d3_q  <= d2_q;
      for (int c = 0; c < 3; c++) begin
        bsa3_q[c] <= b2_q[c] * sa2_q;
      end
      f4_q <= f4_d;
    end
  end

  assign vld_o  = vld_q[3];
  assign data_o = f4_q;
endmodule

// ===== hw/rtl/rab_div.sv =====
// Pipelined restoring divider: a setup stage, then one quotient bit per stage, three channels.
module rab_div import rab_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  front_t             data_i,
  output logic               vld_o,
  output logic [2:0][CW-1:0] rgb_o,
  output logic [CW-1:0]      a_o
);
  typedef struct packed {
    logic               zero;
    logic [AW-1:0]      a2;
    logic [CW-1:0]      oa;
    logic [2:0][NW-1:0] rem;
    logic [2:0][QW-1:0] q;
  } div_t;

  div_t       st_q [QW+1];
  div_t       st_d [QW+1];
  logic [QW:0] vld_q;

  always_comb begin
    logic [NW-1:0] sh;
    st_d[0].zero = data_i.zero;
    st_d[0].a2   = data_i.a2;
    st_d[0].oa   = clamp_full(div_full({1'b0, data_i.a2} + (AW+1)'(HALF)));
    st_d[0].q    = '0;
    for (int c = 0; c < 3; c++) begin
      st_d[0].rem[c] = data_i.num[c] + (NW)'(data_i.a2 >> 1);
    end
    for (int k = 1; k <= QW; k++) begin
      st_d[k] = st_q[k-1];
      sh = (NW)'(st_q[k-1].a2) << (QW - k);
      for (int c = 0; c < 3; c++) begin
        if (st_q[k-1].rem[c] >= sh) begin
          st_d[k].rem[c] = st_q[k-1].rem[c] - sh;
          st_d[k].q[c][QW-k] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= QW; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rgb_o[c] = st_q[QW].zero ? '0 : clamp_full(st_q[QW].q[c]);
    end
    a_o = st_q[QW].zero ? '0 : st_q[QW].oa;
  end

  assign vld_o = vld_q[QW];
endmodule

// ===== hw/rtl/rgba_alpha_blend_modes.sv =====
// Top level of the RGBA alpha blend block with selectable blend modes.
//  channel | signals                                   | role
//  in      | in_valid_i/in_ready_o, dst_*_i, src_*_i   | pixel pair transfer
//  out     | out_valid_o/out_ready_i, out_*_o          | composited pixel transfer
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i           | register write
// One pixel per cycle while the output is not stalled; 4 front stages plus 14 divider stages.
// The per-channel divide by the output alpha sets the depth: a setup stage, then one bit per stage.
// Reset clears the valid bits and restores mode normal, opacity full.
// A stall at the output freezes every stage; nothing is dropped or repeated.
`include "rgba_alpha_blend_modes_macros.svh"
module rgba_alpha_blend_modes import rab_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_idx_i,
  input  logic [CW-1:0] cfg_data_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [CW-1:0] dst_r_i,
  input  logic [CW-1:0] dst_g_i,
  input  logic [CW-1:0] dst_b_i,
  input  logic [CW-1:0] dst_a_i,
  input  logic [CW-1:0] src_r_i,
  input  logic [CW-1:0] src_g_i,
  input  logic [CW-1:0] src_b_i,
  input  logic [CW-1:0] src_a_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [CW-1:0] out_r_o,
  output logic [CW-1:0] out_g_o,
  output logic [CW-1:0] out_b_o,
  output logic [CW-1:0] out_a_o
);
  logic [1:0]         mode_q;
  logic [CW-1:0]      opac_q;
  logic               en;
  logic               fvld;
  front_t             fdata;
  logic [2:0][CW-1:0] rgb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_NORMAL;
      opac_q <= FULL;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_MODE:    mode_q <= cfg_data_i[1:0];
        REG_OPACITY: opac_q <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  rab_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .vld_i   (in_valid_i),
    .mode_i  (mode_q),
    .opac_i  (opac_q),
    .dst_i   ({dst_b_i, dst_g_i, dst_r_i}),
    .dst_a_i (dst_a_i),
    .src_i   ({src_b_i, src_g_i, src_r_i}),
    .src_a_i (src_a_i),
    .vld_o   (fvld),
    .data_o  (fdata)
  );

  rab_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (fvld),
    .data_i (fdata),
    .vld_o  (out_valid_o),
    .rgb_o  (rgb),
    .a_o    (out_a_o)
  );

  assign out_r_o = rgb[0];
  assign out_g_o = rgb[1];
  assign out_b_o = rgb[2];

  `RAB_ASSERT(a_zero_alpha_black, out_valid_o && (out_a_o == '0) |-> (rgb == '0))
  `RAB_ASSERT(a_no_take_on_stall, in_valid_i && in_ready_o |-> !(out_valid_o && !out_ready_i))
  `RAB_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_o)
endmodule

// ===== tb/rgba_alpha_blend_modes_test.sv =====
// Self-checking testbench for the RGBA alpha blend block with its blend modes.
module rgba_alpha_blend_modes_test;
  import rab_pkg::*;

  typedef struct packed {
    logic [CW-1:0] r, g, b, a;
  } pix_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic          cfg_idx_i = 1'b0;
  logic [CW-1:0] cfg_data_i = '0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  logic [CW-1:0] dst_r_i = '0, dst_g_i = '0, dst_b_i = '0, dst_a_i = '0;
  logic [CW-1:0] src_r_i = '0, src_g_i = '0, src_b_i = '0, src_a_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  logic [CW-1:0] out_r_o, out_g_o, out_b_o, out_a_o;

  rgba_alpha_blend_modes dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  mode_e         cur_mode = MODE_NORMAL;
  logic [CW-1:0] cur_opacity = FULL;
  pix_t          expected_pix[$];
  int            mismatches = 0;
  bit            no_idle = 1'b0;
  int            hold_reqs = 0;
  int            hold_done = 0;
  int            hold_len = 0;

  function automatic longint unsigned rdiv(longint unsigned n, longint unsigned d);
    return (d == 0) ? 0 : (n + d / 2) / d;
  endfunction

  function automatic longint unsigned sat(longint unsigned v);
    return (v > FULL) ? FULL : v;
  endfunction

  function automatic longint unsigned blend_chan(mode_e m, longint unsigned d,
                                                 longint unsigned s);
    case (m)
      MODE_ADD:    return sat(d + s);
      MODE_MUL:    return rdiv(d * s, FULL);
      MODE_SCREEN: return FULL - sat(rdiv((FULL - d) * (FULL - s), FULL));
      default:     return s;
    endcase
  endfunction

  function automatic pix_t composite(pix_t d, pix_t s);
    longint unsigned sa, da, a2, wd, dc[3], sc[3];
    pix_t o;
    dc[0] = 64'(d.r); dc[1] = 64'(d.g); dc[2] = 64'(d.b);
    sc[0] = 64'(s.r); sc[1] = 64'(s.g); sc[2] = 64'(s.b);
    da = 64'(d.a);
    sa = sat(rdiv(64'(s.a) * 64'(cur_opacity), FULL));
    a2 = sa * FULL + da * (FULL - sa);
    if (a2 == 0) return '0;
    wd = da * (FULL - sa);
    for (int i = 0; i < 3; i++)
      dc[i] = sat(rdiv(blend_chan(cur_mode, dc[i], sc[i]) * sa * FULL + dc[i] * wd, a2));
    o.r = CW'(dc[0]); o.g = CW'(dc[1]); o.b = CW'(dc[2]);
    o.a = CW'(sat(rdiv(a2, FULL)));
    return o;
  endfunction

  task automatic send_pixel(pix_t d, pix_t s);
    while (!no_idle && $urandom_range(99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    dst_r_i <= d.r; dst_g_i <= d.g; dst_b_i <= d.b; dst_a_i <= d.a;
    src_r_i <= s.r; src_g_i <= s.g; src_b_i <= s.b; src_a_i <= s.a;
    in_valid_i <= 1'b1;
    expected_pix.push_back(composite(d, s));
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_pix.size() != 0) @(posedge clk_i);
    repeat (25) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_e idx, logic [CW-1:0] val);
    drain();
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_MODE) cur_mode = mode_e'(val[1:0]);
    else cur_opacity = val;
  endtask

  function automatic pix_t rand_pix();
    pix_t p;
    p = 48'({$urandom, $urandom});
    case ($urandom_range(7))
      0: p.a = '0;
      1: p.a = FULL;
      default: ;
    endcase
    return p;
  endfunction

  always @(posedge clk_i) begin
    if (hold_len > 0) begin
      out_ready_i <= 1'b0;
      hold_len <= hold_len - 1;
    end else if (hold_done != hold_reqs) begin
      out_ready_i <= 1'b0;
      hold_len <= 300;
      hold_done <= hold_reqs;
    end else begin
      out_ready_i <= no_idle || ($urandom_range(99) >= 6);
    end
  end

  always @(posedge clk_i) begin
    pix_t got, exp_p;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {out_r_o, out_g_o, out_b_o, out_a_o};
      if (expected_pix.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer %h", got);
      end else begin
        exp_p = expected_pix.pop_front();
        if (got !== exp_p) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel: expected r%h g%h b%h a%h, got r%h g%h b%h a%h",
                     exp_p.r, exp_p.g, exp_p.b, exp_p.a, got.r, got.g, got.b, got.a);
        end
      end
    end
  end

  task automatic test_corners();
    logic [CW-1:0] v[4] = '{12'h000, 12'hfff, 12'h800, 12'h7ff};
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_MODE, CW'(m));
      for (int i = 0; i < 4; i++)
        send_pixel({v[i], v[3-i], v[i], v[(i+1)%4]}, {v[3-i], v[i], v[(i+2)%4], v[i]});
    end
    write_reg(REG_OPACITY, '0);
    send_pixel('1, '1);
    send_pixel('0, '0);
    send_pixel({12'h123, 12'h456, 12'h789, 12'h000}, '1);
  endtask

  task automatic test_random(int n);
    repeat (n) send_pixel(rand_pix(), rand_pix());
  endtask

  task automatic test_settings();
    logic [CW-1:0] ops[4] = '{FULL, 12'h000, 12'h001, 12'h800};
    for (int k = 0; k < 12; k++) begin
      write_reg(REG_MODE, CW'(k % 4));
      write_reg(REG_OPACITY, (k < 4) ? ops[k] : CW'($urandom));
      test_random(115);
    end
  endtask

  task automatic test_backpressure();
    write_reg(REG_MODE, CW'(MODE_SCREEN));
    write_reg(REG_OPACITY, FULL);
    hold_reqs++;
    test_random(100);
    drain();
    no_idle = 1'b1;
    test_random(150);
    no_idle = 1'b0;
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corners();
    test_settings();
    test_backpressure();
    drain();
    if (mismatches == 0 && expected_pix.size() == 0) begin
      $display("rgba_alpha_blend_modes: match");
    end else begin
      $display("rgba_alpha_blend_modes: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("rgba_alpha_blend_modes: mismatch");
    $finish;
  end
endmodule
